// ===== rtl/fhdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhdt_pkg
// Shared types and constants for the hundredths-to-decimal-text converter.
// ----------------------------------------------------------------------------
package fhdt_pkg;

  // Input and conversion sizes
  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
  // Lowest integer digit position; positions below it hold the fraction
  localparam int INT_LOW_DIGIT = 2;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC_HI,
    ST_FRAC_LO
  } state_t;

  // Character chosen for the output word
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_SIGN,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC_HI,
    SEL_FRAC_LO
  } char_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      lead_load;
    char_sel_t sel;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic neg;
    logic conv_done;
    logic int_end;
  } stat_t;

endpackage

// ===== rtl/fhdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhdt_ctrl
// Sequencer: runs the binary-to-BCD conversion, then walks the characters
// of the text (sign, integer digits, point, two fraction digits).
// ----------------------------------------------------------------------------
module fhdt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fhdt_pkg::stat_t stat,
  output fhdt_pkg::ctrl_t ctrl
);
  import fhdt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (stat.conv_done) state_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        state_nxt = stat.neg ? ST_SIGN : ST_INT;
      end
      ST_SIGN: begin
        state_nxt = ST_INT;
      end
      ST_INT: begin
        if (stat.int_end) state_nxt = ST_DOT;
      end
      ST_DOT: begin
        state_nxt = ST_FRAC_HI;
      end
      ST_FRAC_HI: begin
        state_nxt = ST_FRAC_LO;
      end
      ST_FRAC_LO: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy           = 1'b1;
    ctrl.load      = 1'b0;
    ctrl.conv_step = 1'b0;
    ctrl.lead_load = 1'b0;
    ctrl.sel       = SEL_NONE;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_CONV: begin
        ctrl.conv_step = 1'b1;
      end
      ST_LEAD: begin
        ctrl.lead_load = 1'b1;
      end
      ST_SIGN: begin
        ctrl.sel = SEL_SIGN;
      end
      ST_INT: begin
        ctrl.sel = SEL_INT;
      end
      ST_DOT: begin
        ctrl.sel = SEL_DOT;
      end
      ST_FRAC_HI: begin
        ctrl.sel = SEL_FRAC_HI;
      end
      ST_FRAC_LO: begin
        ctrl.sel = SEL_FRAC_LO;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/fhdt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhdt_datapath
// Magnitude register, shift-and-add-3 BCD converter (four bits a cycle),
// leading-digit pointer and registered character output.
// ----------------------------------------------------------------------------
module fhdt_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [fhdt_pkg::VALUE_W-1:0]   in_value,
  input  fhdt_pkg::ctrl_t                       ctrl,
  output fhdt_pkg::stat_t                       stat,
  output logic                                  out_valid,
  output logic [7:0]                            out_text_char,
  output logic                                  out_last
);
  import fhdt_pkg::*;

  logic [VALUE_W-1:0]     mag_r;
  logic [VALUE_W-1:0]     mag_nxt;
  logic                   neg_r;
  logic [3:0]             bcd_r   [NUM_DIGITS];
  logic [3:0]             bcd_nxt [NUM_DIGITS];
  logic [STEP_CNT_W-1:0]  step_cnt_r;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic [3:0]             cur_digit;
  logic [7:0]             char_nxt;
  logic                   valid_r;
  logic [7:0]             char_r;
  logic                   last_r;

  // Absolute value, with the most negative input saturated
  always_comb begin
    if (!in_value[VALUE_W-1]) begin
      mag_nxt = in_value;
    end else if (in_value == {1'b1, {(VALUE_W-1){1'b0}}}) begin
      mag_nxt = {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      mag_nxt = VALUE_W'(-in_value);
    end
  end

  // Shift four magnitude bits into the BCD digits, correcting before each
  always_comb begin
    logic [3:0] d [NUM_DIGITS];
    logic       carry;
    for (int k = 0; k < NUM_DIGITS; k++) d[k] = bcd_r[k];
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (d[k] >= 4'd5) d[k] = d[k] + 4'd3;
      end
      carry = mag_r[VALUE_W-1-s];
      for (int k = 0; k < NUM_DIGITS; k++) begin
        {carry, d[k]} = {d[k], carry};
      end
    end
    for (int k = 0; k < NUM_DIGITS; k++) bcd_nxt[k] = d[k];
  end

  // Find the highest nonzero integer digit; the units digit when all are zero
  always_comb begin
    lead_idx = DIGIT_IDX_W'(INT_LOW_DIGIT);
    for (int k = INT_LOW_DIGIT; k < NUM_DIGITS; k++) begin
      if (bcd_r[k] != 4'd0) lead_idx = DIGIT_IDX_W'(k);
    end
  end

  // Conversion registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= mag_nxt;
      neg_r <= in_value[VALUE_W-1];
      for (int k = 0; k < NUM_DIGITS; k++) bcd_r[k] <= 4'd0;
    end else if (ctrl.conv_step) begin
      mag_r <= mag_r << BITS_PER_STEP;
      for (int k = 0; k < NUM_DIGITS; k++) bcd_r[k] <= bcd_nxt[k];
    end
  end

  // Step counter and digit pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
      idx_r      <= '0;
    end else begin
      if (ctrl.load) begin
        step_cnt_r <= '0;
      end else if (ctrl.conv_step) begin
        step_cnt_r <= step_cnt_r + 1'b1;
      end
      if (ctrl.lead_load) begin
        idx_r <= lead_idx;
      end else if (ctrl.sel == SEL_INT) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign stat.neg       = neg_r;
  assign stat.conv_done = (step_cnt_r == STEP_CNT_W'(CONV_STEPS - 1));
  assign stat.int_end   = (idx_r == DIGIT_IDX_W'(INT_LOW_DIGIT));

  assign cur_digit = bcd_r[idx_r];

  // Pick the character for this cycle
  always_comb begin
    case (ctrl.sel)
      SEL_SIGN:    char_nxt = CHAR_MINUS;
      SEL_INT:     char_nxt = CHAR_ZERO + {4'd0, cur_digit};
      SEL_DOT:     char_nxt = CHAR_DOT;
      SEL_FRAC_HI: char_nxt = CHAR_ZERO + {4'd0, bcd_r[1]};
      SEL_FRAC_LO: char_nxt = CHAR_ZERO + {4'd0, bcd_r[0]};
      default:     char_nxt = CHAR_ZERO;
    endcase
  end

  // Register the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.sel != SEL_NONE);
    end
    char_r <= char_nxt;
    last_r <= (ctrl.sel == SEL_FRAC_LO);
  end

  assign out_valid     = valid_r;
  assign out_text_char = char_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/fixed_hundredths_to_decimal_text_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_hundredths_to_decimal_text_top
// Converts a signed value in hundredths to ASCII text, one character a cycle.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its text comes out
// most significant character first, one word per cycle on out_text_char
// with out_valid high for exactly that cycle; out_last marks the final
// fraction digit. The receiver cannot stall the block, so it must take every
// word in the cycle it is shown. After the accepting edge busy stays high
// through the BCD conversion at four bits a cycle, the search for the
// leading digit and the output of the characters (4 to 12 of them). The
// last word is shown in the first cycle with busy low, and a new value may
// be accepted in that cycle.
// The most negative input is shown as -21474836.47.
// ----------------------------------------------------------------------------
module fixed_hundredths_to_decimal_text_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fhdt_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic [7:0]                          out_text_char,
  output logic                                out_last
);
  import fhdt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  fhdt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Conversion and output datapath
  fhdt_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last      (out_last)
  );

endmodule

// ===== test/fixed_hundredths_to_decimal_text_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_hundredths_to_decimal_text_top_test
// Self-checking bench for the hundredths-to-decimal-text converter.
// ----------------------------------------------------------------------------
// A list of values (corner values first, then random values of every length)
// goes to the converter over the start/busy handshake. Sender gaps come in
// random bursts. The bench works out the expected text for each value it
// hands over. A monitor takes every word the block shows and compares it,
// character and last flag, with the oldest character still owed.
// ----------------------------------------------------------------------------
module fixed_hundredths_to_decimal_text_top_test;
  import fhdt_pkg::*;

  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_COUNT   = 185;
  localparam int QUIET_TAIL     = 30;    // last values are sent with no gaps
  localparam int DRAIN_CYCLES   = 30;    // settle time after the last word
  localparam int STALL_LIMIT    = 1000;  // cycles with nothing moving

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } text_word_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_valid;
  logic [7:0]                  out_text_char;
  logic                        out_last;

  logic signed [VALUE_W-1:0]   values_to_send[$];
  text_word_t                  owed_text[$];
  int                          error_count = 0;
  int                          sent_count  = 0;
  int                          gap_left    = 0;
  logic                        gap_on_free = 1'b0;
  int                          quiet_cycles = 0;

  fixed_hundredths_to_decimal_text_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_text_char(out_text_char),
    .out_last     (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append the text of one value to the characters still owed
  function automatic void owe_text_of(input logic signed [VALUE_W-1:0] v);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] whole;
    logic [6:0]  frac;
    logic [3:0]  digit[10];
    int          nd;
    neg = v[VALUE_W-1];
    if (!neg) begin
      mag = v;
    end else if (v == 32'sh80000000) begin
      // most negative value saturates one step up
      mag = 32'h7FFFFFFF;
    end else begin
      mag = -v;
    end
    whole = mag / 100;
    frac  = 7'(mag % 100);
    nd = 0;
    // integer digits, least significant first; a zero part gives one '0'
    do begin
      digit[nd] = 4'(whole % 10);
      whole     = whole / 10;
      nd++;
    end while (whole != 0);
    if (neg) begin
      owed_text.push_back('{text_char: CHAR_MINUS, last: 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      owed_text.push_back('{text_char: CHAR_ZERO + {4'd0, digit[i]}, last: 1'b0});
    end
    owed_text.push_back('{text_char: CHAR_DOT, last: 1'b0});
    owed_text.push_back('{text_char: CHAR_ZERO + 8'(frac / 10), last: 1'b0});
    owed_text.push_back('{text_char: CHAR_ZERO + 8'(frac % 10), last: 1'b1});
  endfunction

  // Random value: full range, a chosen digit count, or near the ends
  function automatic logic signed [VALUE_W-1:0] random_value();
    longint lim;
    longint mag;
    int     pick;
    int     k;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      return $urandom;
    end else if (pick < 8) begin
      k   = $urandom_range(1, 9);
      lim = 1;
      repeat (k) lim = lim * 10;
      mag = longint'($urandom) % lim;
      return VALUE_W'($urandom_range(0, 1) ? -mag : mag);
    end else begin
      mag = $urandom_range(0, 300);
      return VALUE_W'($urandom_range(0, 1) ? 32'sh80000000 + mag : 32'sh7FFFFFFF - mag);
    end
  endfunction

  // Driver: hand over pending values, with bursts of sender gaps
  always @(posedge clk) begin : drive_proc
    logic take;
    int   gap_odds;
    take = rst_n && start && !busy;
    if (take) begin
      owe_text_of(values_to_send[0]);
      void'(values_to_send.pop_front());
      sent_count++;
      // gap odds change by stretch: none, some, many
      case ((sent_count / 35) % 3)
        0: gap_odds = 0;
        1: gap_odds = 30;
        default: gap_odds = 70;
      endcase
      if (values_to_send.size() > QUIET_TAIL && $urandom_range(1, 100) <= gap_odds) begin
        gap_left    = $urandom_range(1, 8);
        gap_on_free = 1'($urandom_range(0, 1));
      end
    end else if (gap_left > 0 && (!gap_on_free || !busy)) begin
      gap_left--;
    end
    if (rst_n && gap_left == 0 && values_to_send.size() != 0) begin
      start    <= 1'b1;
      in_value <= values_to_send[0];
    end else begin
      start    <= 1'b0;
      in_value <= $urandom;
    end
  end

  // Monitor: compare each shown word with the oldest owed character
  always @(posedge clk) begin : check_proc
    text_word_t want;
    if (rst_n && out_valid) begin
      if (owed_text.size() == 0) begin
        $error("unexpected word: text_char %h last %b", out_text_char, out_last);
        error_count++;
      end else begin
        want = owed_text.pop_front();
        if (out_text_char !== want.text_char) begin
          $error("text_char: expected %h actual %h", want.text_char, out_text_char);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus list, reset, then wait for the last word
  initial begin
    logic signed [VALUE_W-1:0] corner[DIRECTED_COUNT];
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    // zero, sub-unit negatives, a spread of digit counts, both ends of the range
    corner = '{0, 1, 5, -5, -1, 9, 10, 99, -99, 100, -100, 101, 1000, -1001,
               12345, -98760, 1234567, 99999999, -100000000, 1999999999,
               32'sh7FFFFFFF, -32'sh7FFFFFFF, 32'sh80000000,
               32'sh55555555, 32'shAAAAAAAA};
    foreach (corner[i]) values_to_send.push_back(corner[i]);
    repeat (RANDOM_COUNT) values_to_send.push_back(random_value());
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (values_to_send.size() != 0 || owed_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_text.size() != 0) begin
      $error("%0d characters never arrived", owed_text.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fhdt_pkg.sv
rtl/fhdt_ctrl.sv
rtl/fhdt_datapath.sv
rtl/fixed_hundredths_to_decimal_text_top.sv
test/fixed_hundredths_to_decimal_text_top_test.sv
